/* rtl/ttbps_pkg.sv */
// ----------------------------------------------------------------------------
// ttbps_pkg
// Shared widths, slot time tables and outcome codes for the timed two-bit
// pair sender.
// ----------------------------------------------------------------------------
package ttbps_pkg;

    localparam int unsigned PAIR_COUNT  = 4;
    localparam int unsigned COUNT_W     = 6;
    localparam int unsigned PAIR_IDX_W  = 2;
    localparam int unsigned S_DATA_W    = 16;
    localparam int unsigned M_DATA_W    = 8;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [1:0]         outcome_t;

    localparam outcome_t OUTCOME_ATN_HIGH = 2'd0;
    localparam outcome_t OUTCOME_ATN_LOW  = 2'd1;
    localparam outcome_t OUTCOME_ABORTED  = 2'd2;

    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_SUBMIT = 1'b1;

    // Slot times in microseconds; the last entry is the final release slot.
    typedef count_t slot_table_t [PAIR_COUNT+1];

    localparam slot_table_t SLOT_PAL  = '{6'd14, 6'd22, 6'd30, 6'd38, 6'd46};
    localparam slot_table_t SLOT_NTSC = '{6'd14, 6'd24, 6'd34, 6'd44, 6'd52};

endpackage

/* rtl/timed_two_bit_pair_sender_unit.sv */
// ----------------------------------------------------------------------------
// timed_two_bit_pair_sender_unit
// Sends one byte over a two-wire serial bus as four timed bit pairs.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle while s_tready is high and returns
// exactly one result beat per input beat, in the cycle after it. A submit beat
// loads a byte when the sender is idle; tick beats, one per microsecond, carry
// the sampled CLK, ATN and bus reset levels and advance the small sender state
// machine. The single output register sets the rate: s_tready is high whenever
// that register is empty or is being read in the same cycle, so a continuously
// ready sink sees one result per cycle. cfg_wr_en writes the PAL/NTSC slot time
// select; the user must write it only while no beat is in flight (not enforced).
module timed_two_bit_pair_sender_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // Fields from bit 0: byte_value[7:0], clk_level, atn_level, reset_idle, zero fill.
    input  logic [ttbps_pkg::S_DATA_W-1:0]   s_tdata,
    // Fields: mode.
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // Fields from bit 0: clk_drive, data_drive, busy_res, byte_done, outcome[1:0],
    // zero fill.
    output logic [ttbps_pkg::M_DATA_W-1:0]   m_tdata
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_LOW,
        PH_WAIT_HIGH,
        PH_SEND,
        PH_HOLD,
        PH_SAMPLE
    } phase_t;

    phase_t                              phase_reg, phase_next;
    ttbps_pkg::count_t                   count_reg, count_next;
    logic [7:0]                          shift_reg, shift_next;
    logic [ttbps_pkg::PAIR_IDX_W-1:0]    pair_reg, pair_next;
    logic                                clk_out_reg, clk_out_next;
    logic                                data_out_reg, data_out_next;
    logic                                video_reg;
    logic                                m_tvalid_reg;
    logic [ttbps_pkg::M_DATA_W-1:0]      m_tdata_reg;

    logic                                accept;
    logic [7:0]                          byte_value;
    logic                                clk_level;
    logic                                atn_level;
    logic                                reset_idle;
    logic                                done;
    ttbps_pkg::outcome_t                 outcome;
    ttbps_pkg::count_t                   count_inc;
    ttbps_pkg::count_t                   pair_slot;
    ttbps_pkg::count_t                   final_slot;

    assign byte_value = s_tdata[7:0];
    assign clk_level  = s_tdata[8];
    assign atn_level  = s_tdata[9];
    assign reset_idle = s_tdata[10];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign count_inc  = count_reg + ttbps_pkg::count_t'(1);
    assign pair_slot  = video_reg ? ttbps_pkg::SLOT_NTSC[pair_reg]
                                  : ttbps_pkg::SLOT_PAL[pair_reg];
    assign final_slot = video_reg ? ttbps_pkg::SLOT_NTSC[ttbps_pkg::PAIR_COUNT]
                                  : ttbps_pkg::SLOT_PAL[ttbps_pkg::PAIR_COUNT];

    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        shift_next    = shift_reg;
        pair_next     = pair_reg;
        clk_out_next  = clk_out_reg;
        data_out_next = data_out_reg;
        done          = 1'b0;
        outcome       = ttbps_pkg::OUTCOME_ATN_HIGH;
        if (s_tuser == ttbps_pkg::MODE_SUBMIT) begin
            if (phase_reg == PH_IDLE) begin
                shift_next    = byte_value;
                data_out_next = 1'b1;
                count_next    = '0;
                pair_next     = '0;
                phase_next    = PH_WAIT_LOW;
            end
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                end
                PH_WAIT_LOW: begin
                    if (!clk_level) begin
                        phase_next = PH_WAIT_HIGH;
                    end else if (!reset_idle) begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                        outcome    = ttbps_pkg::OUTCOME_ABORTED;
                    end
                end
                PH_WAIT_HIGH: begin
                    if (clk_level) begin
                        phase_next = PH_SEND;
                        count_next = '0;
                        pair_next  = '0;
                    end else if (!reset_idle) begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                        outcome    = ttbps_pkg::OUTCOME_ABORTED;
                    end
                end
                PH_SEND: begin
                    count_next = count_inc;
                    if (count_inc == pair_slot) begin
                        clk_out_next  = !shift_reg[0];
                        data_out_next = !shift_reg[1];
                        shift_next    = {2'b00, shift_reg[7:2]};
                        if (pair_reg == ttbps_pkg::PAIR_IDX_W'(ttbps_pkg::PAIR_COUNT - 1)) begin
                            phase_next = PH_HOLD;
                        end else begin
                            pair_next = pair_reg + ttbps_pkg::PAIR_IDX_W'(1);
                        end
                    end
                end
                PH_HOLD: begin
                    count_next = count_inc;
                    if (count_inc == final_slot) begin
                        clk_out_next  = 1'b1;
                        data_out_next = 1'b0;
                        phase_next    = PH_SAMPLE;
                    end
                end
                PH_SAMPLE: begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                    outcome    = atn_level ? ttbps_pkg::OUTCOME_ATN_HIGH
                                           : ttbps_pkg::OUTCOME_ATN_LOW;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            count_reg    <= '0;
            shift_reg    <= '0;
            pair_reg     <= '0;
            clk_out_reg  <= 1'b1;
            data_out_reg <= 1'b0;
            video_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                video_reg <= cfg_wr_data;
            end
            if (accept) begin
                phase_reg    <= phase_next;
                count_reg    <= count_next;
                shift_reg    <= shift_next;
                pair_reg     <= pair_next;
                clk_out_reg  <= clk_out_next;
                data_out_reg <= data_out_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {2'b00, outcome, done, (phase_next != PH_IDLE),
                            data_out_next, clk_out_next};
        end
    end

endmodule

/* rtl/ttbps_checker.sv */
// ----------------------------------------------------------------------------
// ttbps_checker
// Port-level checks for the timed two-bit pair sender, bound to the top level.
// ----------------------------------------------------------------------------
module ttbps_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ttbps_pkg::M_DATA_W-1:0]  m_tdata
);

    // A finished or aborted byte leaves the block idle.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3]) |-> !m_tdata[2])
        else $error("byte_done reported while still busy");

    // The outcome carries a code only on the beat that ends a byte.
    a_outcome_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[3]) |-> (m_tdata[5:4] == ttbps_pkg::OUTCOME_ATN_HIGH))
        else $error("outcome set without byte_done");

    // An abort only happens before sending starts, with DATA still released.
    a_abort_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3] && (m_tdata[5:4] == ttbps_pkg::OUTCOME_ABORTED))
        |-> (m_tdata[1] && m_tdata[0]))
        else $error("aborted byte with a line pulled low");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result beat changed while stalled");

    // One result per input: the block cannot take input while a result stalls.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result stalled");

endmodule

bind timed_two_bit_pair_sender_unit ttbps_checker u_ttbps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
